// ----- rtl/ofs_pkg.sv -----
// Shared types, codes and helpers for the overlay file store.
package ofs_pkg;

   localparam int ADDR_W = 12;
   localparam logic [31:0] JOURNAL_RESET = 32'h4846_5331;
   localparam logic [31:0] JOURNAL_SALT  = 32'h5354_4F52;

   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_WRITE  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_BAD_RANGE = 3'd2;
   localparam logic [2:0] ST_TOO_BIG   = 3'd3;
   localparam logic [2:0] ST_NO_SLOT   = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] name_low;
      logic [63:0] name_high;
      logic [7:0]  offset;
      logic [7:0]  length;
      logic [7:0]  data_byte;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [7:0]  read_byte;
      logic        byte_valid;
      logic        last;
      logic [31:0] digest;
   } rsp_type;

   // One queued job for the back end: a memory write, a read burst and/or a reply.
   typedef struct packed {
      logic              wr_en;
      logic              wr_ovl;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              rd_en;
      logic [7:0]        rd_len;
      logic              rsp_en;
      logic [2:0]        status;
      logic [5:0]        slot;
      logic [31:0]       digest;
   } entry_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_FETCH,
      BK_EMIT
   } back_state_type;

   function automatic logic [31:0] journal_fold(input logic [31:0] old, input logic [31:0] v);
      return {old[26:0], old[31:27]} ^ v ^ JOURNAL_SALT;
   endfunction

endpackage

// ----- rtl/ofs_queue.sv -----
// Four-entry job queue between the front and back ends.
module ofs_queue import ofs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   entry_type  store_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   assign head  = store_ff[rd_ptr_ff];
   assign empty = (count_ff == 3'd0);
   assign full  = (count_ff == 3'd4);

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold job payloads
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/ofs_front.sv -----
// Front end: accepts items, keeps the name table, sizes and journal, queues jobs.
module ofs_front import ofs_pkg::*; #(
   parameter int SLOT_COUNT = 8,
   parameter int FILE_BYTES = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      clear_done,
   input  logic      q_full,
   output logic      push,
   output entry_type push_entry
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [127:0] names_ff [SLOT_COUNT];
   logic [127:0] names_in [SLOT_COUNT];
   logic [6:0]   sizes_ff [SLOT_COUNT];
   logic [6:0]   sizes_in [SLOT_COUNT];
   logic [31:0]  journal_ff, journal_in;
   logic         busy_ff, busy_in;
   logic [2:0]   status_ff, status_in;
   logic [5:0]   slot_ff, slot_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         write_ff, write_in;
   logic [7:0]   off_ff, off_in;
   logic [7:0]   len_ff, len_in;

   logic [127:0]          in_name;
   logic [127:0]          new_name;
   logic [SLOT_COUNT-1:0] match_vec;
   logic                  hit;
   logic [SW-1:0]         hit_idx;
   logic                  free_any;
   logic [SW-1:0]         free_idx;
   logic                  accept;

   assign in_name   = {req_data.name_high, req_data.name_low};
   assign req_stall = !clear_done || q_full;
   assign accept    = req_valid && !req_stall;

   // compare the request name against every stored name
   always_comb begin
      logic nz;
      logic [127:0] sb;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         sb = names_ff[s];
         nz = 1'b1;
         match_vec[s] = (sb[7:0] != 8'd0);
         for (int i = 0; i < 16; i++) begin
            if (nz && (sb[8*i +: 8] != in_name[8*i +: 8])) begin
               match_vec[s] = 1'b0;
            end
            if (sb[8*i +: 8] == 8'd0) begin
               nz = 1'b0;
            end
         end
      end
   end

   // pick the lowest matching slot and the lowest free slot
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if (match_vec[s]) begin
            hit     = 1'b1;
            hit_idx = SW'(s);
         end
         if (names_ff[s][7:0] == 8'd0) begin
            free_any = 1'b1;
            free_idx = SW'(s);
         end
      end
   end

   // zero the name from its first NUL on, byte 15 always zero
   always_comb begin
      logic nz;
      nz       = 1'b1;
      new_name = '0;
      for (int i = 0; i < 15; i++) begin
         if (in_name[8*i +: 8] == 8'd0) begin
            nz = 1'b0;
         end
         if (nz) begin
            new_name[8*i +: 8] = in_name[8*i +: 8];
         end
      end
   end

   // classify the item, then feed its payload byte
   always_comb begin
      logic       do_feed;
      logic       last_b;
      logic [8:0] size9;
      logic [8:0] off9;
      logic [8:0] len9;
      logic [8:0] idx9;
      do_feed    = 1'b0;
      last_b     = req_data.last_byte;
      size9      = {2'b0, sizes_ff[hit_idx]};
      off9       = {1'b0, req_data.offset};
      len9       = {1'b0, req_data.length};
      idx9       = '0;
      names_in   = names_ff;
      sizes_in   = sizes_ff;
      journal_in = journal_ff;
      busy_in    = busy_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      write_in   = write_ff;
      off_in     = off_ff;
      len_in     = len_ff;
      push       = 1'b0;
      push_entry = '0;

      if (accept) begin
         if (busy_ff) begin
            do_feed = 1'b1;
         end else begin
            case (req_data.kind)
               KIND_CREATE: begin
                  write_in = 1'b0;
                  off_in   = '0;
                  len_in   = req_data.length;
                  slot_in  = '0;
                  cnt_in   = '0;
                  busy_in  = 1'b1;
                  do_feed  = 1'b1;
                  if (len9 > 9'(FILE_BYTES)) begin
                     status_in = ST_TOO_BIG;
                  end else if (free_any) begin
                     status_in          = ST_OK;
                     slot_in            = 6'(free_idx);
                     names_in[free_idx] = new_name;
                     sizes_in[free_idx] = req_data.length[6:0];
                  end else begin
                     status_in = ST_NO_SLOT;
                  end
               end
               KIND_WRITE: begin
                  write_in = 1'b1;
                  off_in   = req_data.offset;
                  len_in   = req_data.length;
                  slot_in  = '0;
                  cnt_in   = '0;
                  busy_in  = 1'b1;
                  do_feed  = 1'b1;
                  if (!hit) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     slot_in   = 6'(hit_idx);
                     status_in = (off9 > size9 || len9 > size9 - off9) ? ST_BAD_RANGE : ST_OK;
                  end
               end
               KIND_READ: begin
                  push              = 1'b1;
                  push_entry.digest = journal_ff;
                  push_entry.rsp_en = 1'b1;
                  if (!hit) begin
                     push_entry.status = ST_NOT_FOUND;
                  end else if (off9 > size9 || len9 > size9 - off9) begin
                     push_entry.status = ST_BAD_RANGE;
                  end else if (req_data.length == 8'd0) begin
                     push_entry.status = ST_OK;
                  end else begin
                     push_entry.rsp_en = 1'b0;
                     push_entry.rd_en  = 1'b1;
                     push_entry.rd_len = req_data.length;
                     push_entry.addr   = ADDR_W'(hit_idx) * ADDR_W'(FILE_BYTES)
                                         + ADDR_W'(req_data.offset);
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (do_feed) begin
         idx9 = write_in ? ({1'b0, off_in} + {1'b0, cnt_in}) : {1'b0, cnt_in};
         if (status_in == ST_OK && cnt_in < len_in && idx9 < 9'(FILE_BYTES)) begin
            push             = 1'b1;
            push_entry.wr_en = 1'b1;
            push_entry.wr_ovl = write_in;
            push_entry.data  = req_data.data_byte;
            push_entry.addr  = ADDR_W'(slot_in) * ADDR_W'(FILE_BYTES) + ADDR_W'(idx9);
         end
         if (cnt_in != 8'd255) begin
            cnt_in = cnt_in + 8'd1;
         end
         if (last_b) begin
            busy_in = 1'b0;
            if (status_in == ST_OK) begin
               journal_in = write_in ? journal_fold(journal_ff, {24'd0, off_in ^ len_in})
                                     : journal_fold(journal_ff, {24'd0, {2'b0, slot_in} ^ len_in});
            end
            push              = 1'b1;
            push_entry.rsp_en = 1'b1;
            push_entry.status = status_in;
            push_entry.slot   = (!write_in && status_in == ST_OK) ? slot_in : 6'd0;
            push_entry.digest = journal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            names_ff[s] <= '0;
            sizes_ff[s] <= '0;
         end
         journal_ff <= JOURNAL_RESET;
         busy_ff    <= 1'b0;
         status_ff  <= ST_OK;
         slot_ff    <= '0;
         cnt_ff     <= '0;
         write_ff   <= 1'b0;
         off_ff     <= '0;
         len_ff     <= '0;
      end else begin
         names_ff   <= names_in;
         sizes_ff   <= sizes_in;
         journal_ff <= journal_in;
         busy_ff    <= busy_in;
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         cnt_ff     <= cnt_in;
         write_ff   <= write_in;
         off_ff     <= off_in;
         len_ff     <= len_in;
      end
   end

endmodule

// ----- rtl/ofs_back.sv -----
// Back end: byte memories, clearing pass, read bursts and the result register.
module ofs_back import ofs_pkg::*; #(
   parameter int SLOT_COUNT = 8,
   parameter int FILE_BYTES = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      empty,
   output logic      pop,
   output logic      clear_done,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam int DEPTH = SLOT_COUNT * FILE_BYTES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [7:0] base_mem [DEPTH];
   logic [7:0] ovl_mem  [DEPTH];
   logic       mark_mem [DEPTH];

   back_state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [AW-1:0]  rd_addr_ff, rd_addr_in;
   logic [7:0]     remain_ff, remain_in;
   logic [31:0]    digest_ff, digest_in;
   logic           out_valid_ff;
   rsp_type        out_ff;
   logic [7:0]     base_q_ff;
   logic [7:0]     ovl_q_ff;
   logic           mark_q_ff;

   logic    out_free;
   logic    emit;
   logic    load;
   rsp_type load_val;
   logic    clearing;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign clear_done = (state_ff != BK_CLEAR);
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = BK_IDLE;
         BK_IDLE:  if (pop && head.rd_en) state_in = BK_FETCH;
         BK_FETCH: state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_free) state_in = (remain_ff == 8'd1) ? BK_IDLE : BK_FETCH;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      clearing   = 1'b0;
      pop        = 1'b0;
      emit       = 1'b0;
      clr_in     = clr_ff;
      rd_addr_in = rd_addr_ff;
      remain_in  = remain_ff;
      digest_in  = digest_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            clr_in   = clr_ff + AW'(1);
         end
         BK_IDLE: begin
            pop = !empty && (!head.rsp_en || out_free);
            if (pop && head.rd_en) begin
               rd_addr_in = head.addr[AW-1:0];
               remain_in  = head.rd_len;
               digest_in  = head.digest;
            end
         end
         BK_FETCH: begin
         end
         BK_EMIT: begin
            emit = out_free;
            if (out_free) begin
               rd_addr_in = rd_addr_ff + AW'(1);
               remain_in  = remain_ff - 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // pick the next result: a read byte or a queued reply
   always_comb begin
      load     = (pop && head.rsp_en) || emit;
      load_val = '0;
      if (emit) begin
         load_val.status     = ST_OK;
         load_val.read_byte  = mark_q_ff ? ovl_q_ff : base_q_ff;
         load_val.byte_valid = 1'b1;
         load_val.last       = (remain_ff == 8'd1);
         load_val.digest     = digest_ff;
      end else begin
         load_val.status = head.status;
         load_val.slot   = head.slot;
         load_val.last   = 1'b1;
         load_val.digest = head.digest;
      end
   end

   // write and read the byte memories
   always_ff @(posedge clock) begin
      if (clearing) begin
         base_mem[clr_ff] <= '0;
      end else if (pop && head.wr_en && !head.wr_ovl) begin
         base_mem[head.addr[AW-1:0]] <= head.data;
      end
      base_q_ff <= base_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         ovl_mem[clr_ff] <= '0;
      end else if (pop && head.wr_en && head.wr_ovl) begin
         ovl_mem[head.addr[AW-1:0]] <= head.data;
      end
      ovl_q_ff <= ovl_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         mark_mem[clr_ff] <= 1'b0;
      end else if (pop && head.wr_en && head.wr_ovl) begin
         mark_mem[head.addr[AW-1:0]] <= 1'b1;
      end
      mark_q_ff <= mark_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rd_addr_ff   <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rd_addr_ff <= rd_addr_in;
         remain_ff  <= remain_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // hold the result payload and burst digest
   always_ff @(posedge clock) begin
      digest_ff <= digest_in;
      if (load) begin
         out_ff <= load_val;
      end
   end

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !out_valid_ff)
      else $error("result shown during clearing pass");

   a_reply_needs_room: assert property (@(posedge clock) disable iff (reset)
      (pop && head.rsp_en) |-> out_free)
      else $error("reply popped while result register busy");

   a_burst_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FETCH || state_ff == BK_EMIT) |-> (remain_ff != 8'd0))
      else $error("read burst with no bytes left");

endmodule

// ----- rtl/overlay_file_store.sv -----
// Overlay file store top level: front end, job queue and back end.
//
//   port group   dir  payload    meaning
//   req_         in   req_type   command items: create, read, write payload bytes
//   rsp_         out  rsp_type   results: one reply, or one per read byte
//
// Create and write items enter the front end while req_stall is low; read data
// streams one byte per FETCH/EMIT pass, limited by the registered memory read.
// After reset a clearing pass over all SLOT_COUNT*FILE_BYTES addresses zeroes
// the byte memories; req_stall stays high until it ends. req_stall also rises
// when the four-entry job queue is full; rsp_stall holds the result register.
module overlay_file_store import ofs_pkg::*; #(
   parameter int SLOT_COUNT = 8,
   parameter int FILE_BYTES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;
   logic      clear_done;

   ofs_front #(.SLOT_COUNT(SLOT_COUNT), .FILE_BYTES(FILE_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .clear_done (clear_done),
      .q_full     (full),
      .push       (push),
      .push_entry (push_entry)
   );

   ofs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   ofs_back #(.SLOT_COUNT(SLOT_COUNT), .FILE_BYTES(FILE_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .clear_done (clear_done),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
